>>> hdl/adaptive_cpu_freq_governor_defines.svh
// Assertion macros shared by the governor RTL.
`ifndef ADAPTIVE_CPU_FREQ_GOVERNOR_DEFINES_SVH
`define ADAPTIVE_CPU_FREQ_GOVERNOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ACFG_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);
// Condition must never be seen outside reset.
`define ACFG_NEVER(lbl, clk_s, rst_n_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(cond)) else $error(msg);
`else
`define ACFG_ASSERT(lbl, clk_s, rst_n_s, prop, msg)
`define ACFG_NEVER(lbl, clk_s, rst_n_s, cond, msg)
`endif
`endif

>>> hdl/acfg_pkg.sv
// Shared widths, register indexes and constants of the frequency governor.
`timescale 1ns / 1ps
package acfg_pkg;
	localparam int MARK_W     = 7;
	localparam int LOAD_W     = 10;
	localparam int LVL_W      = 16;
	localparam int LIDX_W     = 3;
	localparam int CNT_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int TAB_DEPTH  = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_RUNNING_MARK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_MARK    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_HIGH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_FREQ   = 3'd5;

	localparam logic [MARK_W-1:0] RST_RUNNING_MARK = 7'd75;
	localparam logic [MARK_W-1:0] RST_IDLE_MARK    = 7'd50;
	localparam logic [CNT_W-1:0]  RST_LEVEL_COUNT  = 4'd1;
	localparam logic [LVL_W-1:0]  RST_START_FREQ   = 16'd1;

	localparam logic [LOAD_W-1:0] BUSY_LIMIT = 10'd95;
	localparam logic [LOAD_W-1:0] DOWN_MUL   = 10'd7;
	localparam int                DOWN_SHIFT = 3;
endpackage

>>> hdl/adaptive_cpu_freq_governor.sv
// Top level of the adaptive CPU frequency governor: sequencer, shared multiplier, divider.
// A tick with zero frequency is skipped and leaves the sequencer idle; others search the
// current level, then hold, double or scale the target through the divider or take the idle
// path, and search the target's level; a stalled result waits in the output state.
// Level searches step one table entry a cycle and the serial divider sets the long path.
// Reset clears the sequencer and result valid and loads the register reset values.
`timescale 1ns / 1ps
`include "adaptive_cpu_freq_governor_defines.svh"
module adaptive_cpu_freq_governor #(
	parameter int MAX_LEVELS = 8,
	parameter int FREQ_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [acfg_pkg::LVL_W-1:0]      current_freq,
	input  logic [acfg_pkg::LOAD_W-1:0]     cpu_load,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [acfg_pkg::LVL_W-1:0]      new_freq,
	output logic [acfg_pkg::LIDX_W-1:0]     new_level,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [acfg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acfg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import acfg_pkg::*;

	localparam int AW = (FREQ_BITS > LVL_W) ? FREQ_BITS : LVL_W;
	localparam int PW = AW + LOAD_W;
	localparam logic [PW-1:0]    FMAX    = {{(PW - FREQ_BITS){1'b0}}, {FREQ_BITS{1'b1}}};
	localparam logic [CNT_W-1:0] LVL_MAX = CNT_W'(MAX_LEVELS);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_SRCH      = 4'd1;
	localparam logic [3:0] ST_DECIDE    = 4'd2;
	localparam logic [3:0] ST_MUL_SCALE = 4'd3;
	localparam logic [3:0] ST_DIV_START = 4'd4;
	localparam logic [3:0] ST_DIV_WAIT  = 4'd5;
	localparam logic [3:0] ST_MUL_DOWN  = 4'd6;
	localparam logic [3:0] ST_SET_DOWN  = 4'd7;
	localparam logic [3:0] ST_MUL_CL    = 4'd8;
	localparam logic [3:0] ST_MUL_LM    = 4'd9;
	localparam logic [3:0] ST_CMP       = 4'd10;
	localparam logic [3:0] ST_FINAL     = 4'd11;
	localparam logic [3:0] ST_OUT       = 4'd12;

	localparam logic [1:0] PH_CUR  = 2'd0;
	localparam logic [1:0] PH_DOWN = 2'd1;
	localparam logic [1:0] PH_NEW  = 2'd2;

	function automatic logic [FREQ_BITS-1:0] sat_f(input logic [PW-1:0] x);
		return (x > FMAX) ? {FREQ_BITS{1'b1}} : x[FREQ_BITS-1:0];
	endfunction

	// configuration
	logic [MARK_W-1:0]     run_mark_q;
	logic [MARK_W-1:0]     idle_mark_q;
	logic [CNT_W-1:0]      lvl_cnt_q;
	logic [CFG_DATA_W-1:0] lvl_lo_q;
	logic [CFG_DATA_W-1:0] lvl_hi_q;
	logic [LVL_W-1:0]      start_freq_q;

	// control
	logic [3:0]           state_q;
	logic [1:0]           phase_q;
	logic [CNT_W-1:0]     k_q;
	logic [LIDX_W-1:0]    cur_lvl_q;
	logic [FREQ_BITS-1:0] target_q;
	logic                 out_valid_q;

	// payload
	logic [LVL_W-1:0]     cur_q;
	logic [LOAD_W-1:0]    load_q;
	logic [AW-1:0]        srch_q;
	logic [LVL_W-1:0]     found_q;
	logic [LVL_W-1:0]     dl_freq_q;
	logic [FREQ_BITS-1:0] down_q;
	logic [PW-1:0]        mul_q;
	logic [PW-1:0]        prod_q;
	logic [LVL_W-1:0]     new_freq_q;
	logic [LIDX_W-1:0]    new_level_q;

	logic [LVL_W-1:0]  lvl_tab [TAB_DEPTH];
	logic [CNT_W-1:0]  lvl_n;
	logic [LIDX_W-1:0] low_idx;
	logic [CNT_W-1:0]  k_m1;
	logic [LVL_W-1:0]  lv_k;
	logic              srch_step;
	logic              in_acc;
	logic              cfg_wr;
	logic              load_hi;
	logic              load_big;
	logic              load_lo;
	logic [AW-1:0]     mul_a;
	logic [LOAD_W-1:0] mul_b;
	logic [PW-1:0]     mul_p;
	logic [PW-1:0]     top_ext;
	logic [PW-1:0]     low_ext;
	logic [PW-1:0]     dbl;
	logic [PW-1:0]     dbl_f;
	logic [PW-1:0]     quo_f;
	logic [PW-1:0]     dn_ext;
	logic [PW-1:0]     dn_f;
	logic [LVL_W-1:0]  st_val;
	logic              div_start;
	logic              div_done;
	logic [PW-1:0]     div_quo;

	for (genvar i = 0; i < TAB_DEPTH; i++) begin : g_tab
		if (i < TAB_DEPTH / 2) begin : g_lo
			assign lvl_tab[i] = lvl_lo_q[LVL_W*i +: LVL_W];
		end else begin : g_hi
			assign lvl_tab[i] = lvl_hi_q[LVL_W*(i - TAB_DEPTH/2) +: LVL_W];
		end
	end

	assign lvl_n = (lvl_cnt_q == '0) ? CNT_W'(1) :
		(lvl_cnt_q > LVL_MAX) ? LVL_MAX : lvl_cnt_q;
	assign low_idx = LIDX_W'(lvl_n - CNT_W'(1));

	// search walks down the table while the next entry still covers the operand
	assign k_m1      = k_q - CNT_W'(1);
	assign lv_k      = lvl_tab[k_q[LIDX_W-1:0]];
	assign srch_step = (k_q < lvl_n) && (AW'(lv_k) >= srch_q);

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_wr   = cfg_valid && cfg_ready;
	// take register writes only while no tick is in flight
	assign cfg_ready = (state_q == ST_IDLE);

	assign load_hi  = load_q > LOAD_W'(run_mark_q);
	assign load_big = (load_q > BUSY_LIMIT) || (load_q > LOAD_W'({run_mark_q, 1'b0}));
	assign load_lo  = load_q < LOAD_W'(idle_mark_q);

	always_comb begin
		case (state_q)
			ST_MUL_SCALE: begin
				mul_a = AW'(target_q);
				mul_b = load_q;
			end
			ST_MUL_DOWN: begin
				mul_a = AW'(target_q);
				mul_b = DOWN_MUL;
			end
			ST_MUL_CL: begin
				mul_a = AW'(cur_q);
				mul_b = load_q;
			end
			ST_MUL_LM: begin
				mul_a = AW'(dl_freq_q);
				mul_b = LOAD_W'(run_mark_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = PW'(mul_a) * PW'(mul_b);

	assign top_ext = PW'(lvl_tab[0]);
	assign low_ext = PW'(lvl_tab[low_idx]);
	assign dbl     = PW'(target_q) << 1;
	assign dbl_f   = (dbl > top_ext) ? top_ext : dbl;
	assign quo_f   = (div_quo > top_ext) ? top_ext : div_quo;
	assign dn_ext  = PW'(down_q);
	assign dn_f    = (dn_ext < low_ext) ? low_ext : dn_ext;
	assign st_val  = (cfg_data[LVL_W-1:0] == '0) ? LVL_W'(1) : cfg_data[LVL_W-1:0];

	assign div_start = (state_q == ST_DIV_START);

	acfg_divider #(
		.DW(PW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_q),
		.divisor  (run_mark_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mark_q   <= RST_RUNNING_MARK;
			idle_mark_q  <= RST_IDLE_MARK;
			lvl_cnt_q    <= RST_LEVEL_COUNT;
			lvl_lo_q     <= '0;
			lvl_hi_q     <= '0;
			start_freq_q <= RST_START_FREQ;
			target_q     <= sat_f(PW'(RST_START_FREQ));
			state_q      <= ST_IDLE;
			phase_q      <= PH_CUR;
			k_q          <= CNT_W'(1);
			cur_lvl_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					CFG_RUNNING_MARK: run_mark_q  <= cfg_data[MARK_W-1:0];
					CFG_IDLE_MARK:    idle_mark_q <= cfg_data[MARK_W-1:0];
					CFG_LEVEL_COUNT:  lvl_cnt_q   <= cfg_data[CNT_W-1:0];
					CFG_LEVELS_LOW:   lvl_lo_q    <= cfg_data;
					CFG_LEVELS_HIGH:  lvl_hi_q    <= cfg_data;
					CFG_START_FREQ: begin
						start_freq_q <= cfg_data[LVL_W-1:0];
						target_q     <= sat_f(PW'(st_val));
					end
					default: ;
				endcase
			end

			// drop the result once its transfer completes, unless a new one replaces it
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (current_freq != '0)) begin
						k_q     <= CNT_W'(1);
						phase_q <= PH_CUR;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (srch_step) begin
						k_q <= k_q + CNT_W'(1);
					end else begin
						unique case (phase_q)
							PH_CUR: begin
								cur_lvl_q <= k_m1[LIDX_W-1:0];
								state_q   <= ST_DECIDE;
							end
							PH_DOWN: state_q <= ST_MUL_CL;
							PH_NEW: state_q <= (k_m1[LIDX_W-1:0] != cur_lvl_q) ? ST_OUT : ST_IDLE;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DECIDE: begin
					if (load_hi) begin
						if (load_big) begin
							target_q <= sat_f(dbl_f);
							state_q  <= ST_FINAL;
						end else begin
							state_q <= ST_MUL_SCALE;
						end
					end else if (load_lo) begin
						state_q <= ST_MUL_DOWN;
					end else begin
						state_q <= ST_FINAL;
					end
				end
				ST_MUL_SCALE: state_q <= ST_DIV_START;
				ST_DIV_START: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						target_q <= sat_f(quo_f);
						state_q  <= ST_FINAL;
					end
				end
				ST_MUL_DOWN: state_q <= ST_SET_DOWN;
				ST_SET_DOWN: begin
					k_q     <= CNT_W'(1);
					phase_q <= PH_DOWN;
					state_q <= ST_SRCH;
				end
				ST_MUL_CL: state_q <= ST_MUL_LM;
				ST_MUL_LM: state_q <= ST_CMP;
				ST_CMP: begin
					if (prod_q < mul_q) begin
						target_q <= sat_f(dn_f);
					end
					state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					k_q     <= CNT_W'(1);
					phase_q <= PH_NEW;
					state_q <= ST_SRCH;
				end
				ST_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_q   <= current_freq;
				load_q  <= cpu_load;
				srch_q  <= AW'(current_freq);
				found_q <= lvl_tab[0];
			end
			ST_SRCH: begin
				if (srch_step) begin
					found_q <= lv_k;
				end else if (phase_q == PH_DOWN) begin
					dl_freq_q <= found_q;
				end
			end
			ST_MUL_SCALE, ST_MUL_DOWN, ST_MUL_CL: mul_q <= mul_p;
			ST_SET_DOWN: begin
				down_q  <= mul_q[FREQ_BITS+DOWN_SHIFT-1:DOWN_SHIFT];
				srch_q  <= AW'(mul_q[FREQ_BITS+DOWN_SHIFT-1:DOWN_SHIFT]);
				found_q <= lvl_tab[0];
			end
			ST_MUL_LM: begin
				prod_q <= mul_q;
				mul_q  <= mul_p;
			end
			ST_FINAL: begin
				srch_q  <= AW'(target_q);
				found_q <= lvl_tab[0];
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					new_freq_q  <= found_q;
					new_level_q <= k_m1[LIDX_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign new_freq  = new_freq_q;
	assign new_level = new_level_q;

	`ACFG_ASSERT(a_skip_zero, clk, arst_n, in_valid && !in_stall && current_freq == '0 |=> !in_stall, "zero frequency tick not skipped")
	`ACFG_ASSERT(a_level_changed, clk, arst_n, $rose(out_valid) |-> new_level != cur_lvl_q, "result issued for unchanged level")
	`ACFG_ASSERT(a_srch_range, clk, arst_n, state_q == ST_SRCH |-> k_q != '0 && k_q <= LVL_MAX, "search index out of table")
	`ACFG_NEVER(a_start_unused, clk, arst_n, start_freq_q == '0 && target_q == '0 && state_q == ST_IDLE && !out_valid && $past(cfg_wr) && $past(cfg_index) == CFG_START_FREQ, "start write left zero target")
endmodule

>>> hdl/acfg_divider.sv
// Restoring serial divider: one quotient bit per cycle by a narrow divisor.
`timescale 1ns / 1ps
`include "adaptive_cpu_freq_governor_defines.svh"
module acfg_divider #(
	parameter int DW = 26
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DW-1:0]              dividend,
	input  logic [acfg_pkg::MARK_W-1:0] divisor,
	output logic                       done,
	output logic [DW-1:0]              quotient
);
	import acfg_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DW-1:0]     quo_q;
	logic [MARK_W-1:0] rem_q;
	logic [MARK_W-1:0] dvs_q;
	logic [MARK_W:0]   rem_sh;
	logic [MARK_W:0]   rem_sub;
	logic              ge;

	assign rem_sh  = {rem_q, quo_q[DW-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits the narrow register
			rem_q <= ge ? rem_sub[MARK_W-1:0] : rem_sh[MARK_W-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	`ACFG_ASSERT(a_div_cnt_live, clk, arst_n, busy_q |-> cnt_q != '0, "divider busy with zero count")
	`ACFG_ASSERT(a_div_done_idle, clk, arst_n, done_q |-> !busy_q, "divider done while busy")
	`ACFG_ASSERT(a_div_done_pulse, clk, arst_n, done_q |=> !done_q, "divider done held twice")
endmodule
